// ===== rtl/smt_pkg.sv =====
// Shared types and constants for the sorted multiset table.
`timescale 1ns / 1ps
package smt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int CNT_OUT_W    = 5;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic [VALUE_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== rtl/smt_cell.sv =====
// One storage cell of the sorted chain: holds a value and its valid bit.
`timescale 1ns / 1ps
module smt_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  smt_pkg::cell_ctrl_t         ctrl_i,
  input  logic [smt_pkg::VALUE_W-1:0] left_val_i,
  input  logic                        left_vld_i,
  input  logic                        left_place_i,
  input  logic [smt_pkg::VALUE_W-1:0] right_val_i,
  input  logic                        right_vld_i,
  input  logic                        seen_i,
  output logic [smt_pkg::VALUE_W-1:0] val_o,
  output logic                        vld_o,
  output logic                        place_o,
  output logic                        seen_o
);

  logic [smt_pkg::VALUE_W-1:0] val_q, val_d;
  logic                        vld_q, vld_d;
  logic                        match;

  // empty cells count as greater: entries are packed from the left
  assign place_o = !vld_q || ($signed(val_q) > $signed(ctrl_i.key));
  assign match   = vld_q && (val_q == ctrl_i.key);
  assign seen_o  = seen_i || match;

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.ins) begin
      if (left_place_i) begin
        val_d = left_val_i;
        vld_d = left_vld_i;
      end else if (place_o) begin
        val_d = ctrl_i.key;
        vld_d = 1'b1;
      end
    end else if (ctrl_i.del && seen_o) begin
      // close the gap left by the first matching copy
      val_d = right_val_i;
      vld_d = right_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

// ===== rtl/sorted_multiset_table_core.sv =====
// Top level of the sorted multiset table: cell chain plus sequencer.
`timescale 1ns / 1ps
//
//  channel  | dir | tdata                      | tuser
//  ---------+-----+----------------------------+-------------------------
//  s_axis   | in  | [31:0] value (signed)      | [0] command (0 ins, 1 rm)
//  m_axis   | out | [0] ok, [5:1] entry_count, | -
//           |     | [10:6] removed_count       |
//
//  Insert: all cells compare against the key in parallel and the
//  cells right of the insertion point shift by one.
//  Remove of k copies: each scan cycle drops the first match by
//  shifting the cells right of it left by one, the last scan finds none.
//  A new word is taken only in idle with the output register free or
//  draining. Reset clears valid bits, counts and the output register.
//
module sorted_multiset_table_core #(
  parameter int CAPACITY = smt_pkg::CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [smt_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,   // [31:0] value
  input  logic [0:0]                     s_axis_tuser_i,   // [0] command
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [smt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o    // ok, entry_count, removed_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VW    = smt_pkg::VALUE_W;

  smt_pkg::state_e     state_q, state_d;
  smt_pkg::cell_ctrl_t ctrl;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [VW-1:0]    key_q, key_d;
  logic             out_vld_q, out_vld_d;
  logic [smt_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic in_fire, slot_free, full, any_match, is_insert;
  logic load;
  logic load_ok;
  logic [CNT_W-1:0] load_cnt, load_rem;
  logic [CNT_W+smt_pkg::CNT_OUT_W-1:0] cnt_ext, rem_ext;

  logic [VW-1:0]       cval  [CAPACITY];
  logic [CAPACITY-1:0] cvld, cplace, cseen;

  assign slot_free       = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == smt_pkg::ST_IDLE) && slot_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign is_insert       = (s_axis_tuser_i[0] == smt_pkg::CMD_INSERT);
  assign full            = (cnt_q == CNT_W'(CAPACITY));
  assign any_match       = cseen[CAPACITY-1];

  // ---------------- cell chain ----------------
  assign ctrl.ins = in_fire && is_insert && !full;
  assign ctrl.del = (state_q == smt_pkg::ST_SCAN) && any_match;
  assign ctrl.key = (state_q == smt_pkg::ST_IDLE) ? s_axis_tdata_i : key_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] lval, rval;
    logic          lvld, lplace, rvld, sin;
    if (i == 0) begin : g_first
      assign lval   = '0;
      assign lvld   = 1'b0;
      assign lplace = 1'b0;
      assign sin    = 1'b0;
    end else begin : g_mid
      assign lval   = cval[i-1];
      assign lvld   = cvld[i-1];
      assign lplace = cplace[i-1];
      assign sin    = cseen[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rval = '0;
      assign rvld = 1'b0;
    end else begin : g_inner
      assign rval = cval[i+1];
      assign rvld = cvld[i+1];
    end
    smt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_val_i   (lval),
      .left_vld_i   (lvld),
      .left_place_i (lplace),
      .right_val_i  (rval),
      .right_vld_i  (rvld),
      .seen_i       (sin),
      .val_o        (cval[i]),
      .vld_o        (cvld[i]),
      .place_o      (cplace[i]),
      .seen_o       (cseen[i])
    );
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      smt_pkg::ST_IDLE: begin
        if (in_fire && !is_insert) state_d = smt_pkg::ST_SCAN;
      end
      smt_pkg::ST_SCAN: begin
        if (!any_match) state_d = smt_pkg::ST_DONE;
      end
      smt_pkg::ST_DONE: begin
        if (slot_free) state_d = smt_pkg::ST_IDLE;
      end
      default: state_d = smt_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer: datapath and result ----------------
  always_comb begin
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    key_d    = key_q;
    load     = 1'b0;
    load_ok  = 1'b0;
    load_cnt = cnt_q;
    load_rem = '0;
    case (state_q)
      smt_pkg::ST_IDLE: begin
        if (in_fire) begin
          key_d = s_axis_tdata_i;
          rem_d = '0;
          if (is_insert) begin
            load    = 1'b1;
            load_ok = !full;
            if (!full) begin
              cnt_d    = cnt_q + CNT_W'(1);
              load_cnt = cnt_q + CNT_W'(1);
            end
          end
        end
      end
      smt_pkg::ST_SCAN: begin
        if (any_match) begin
          rem_d = rem_q + CNT_W'(1);
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      smt_pkg::ST_DONE: begin
        load     = slot_free;
        load_ok  = (rem_q != '0);
        load_rem = rem_q;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // counts are reported modulo 32
  assign cnt_ext = {{smt_pkg::CNT_OUT_W{1'b0}}, load_cnt};
  assign rem_ext = {{smt_pkg::CNT_OUT_W{1'b0}}, load_rem};

  always_comb begin
    out_data_d = out_data_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    if (load) begin
      out_vld_d  = 1'b1;
      out_data_d = '0;
      out_data_d[0]    = load_ok;
      out_data_d[5:1]  = cnt_ext[smt_pkg::CNT_OUT_W-1:0];
      out_data_d[10:6] = rem_ext[smt_pkg::CNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= smt_pkg::ST_IDLE;
      cnt_q      <= '0;
      rem_q      <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rem_q      <= rem_d;
      out_vld_q  <= out_vld_d;
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== rtl/smt_checker.sv =====
// Port-level checks for the sorted multiset table, bound to the top level.
`timescale 1ns / 1ps
module smt_checker #(
  parameter int CAPACITY = smt_pkg::CAPACITY_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [0:0]                     s_axis_tuser_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [smt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam logic SMALL = (CAPACITY < 32);

  // a word is never taken while the previous result is stuck
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |-> !(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input taken while result stalled");

  // insert answers in the next cycle
  a_insert_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == smt_pkg::CMD_INSERT))
    |=> m_axis_tvalid_o)
    else $error("insert result missing");

  // failure never reports removed copies
  a_fail_no_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |-> (m_axis_tdata_o[10:6] == 5'd0))
    else $error("failed result with removed copies");

  // count never beyond capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && SMALL) |-> (32'(m_axis_tdata_o[5:1]) <= 32'(CAPACITY)))
    else $error("entry count beyond capacity");

  // successful insert leaves at least one entry
  a_insert_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && SMALL && m_axis_tdata_o[0] && (m_axis_tdata_o[10:6] == 5'd0))
    |-> (m_axis_tdata_o[5:1] != 5'd0))
    else $error("successful insert with empty table");

endmodule

bind sorted_multiset_table_core smt_checker #(.CAPACITY(CAPACITY)) u_smt_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the sorted multiset table core.
`timescale 1ns / 1ps
module tb_top;
  import smt_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = CAPACITY + 8;  // longest remove plus output slack

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic                 ok;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [CNT_OUT_W-1:0] removed_count;
  } table_result_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [0:0]            s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // Shadow copy of the table, updated when a word is accepted
  logic signed [VALUE_W-1:0] shadow_vals [CAPACITY];
  int                        shadow_count = 0;
  table_result_t             pending_results [$];
  table_result_t             head_r;

  int error_count  = 0;
  int cycle_count  = 0;
  int sent_count   = 0;
  int n_ins_ok     = 0;
  int n_ins_full   = 0;
  int n_rm_ok      = 0;
  int n_rm_absent  = 0;
  int max_copies   = 0;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  int rx_stall_left = 0;
  int insert_pct   = 75;

  sorted_multiset_table_core #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output side backpressure: random stall bursts
  always @(posedge clk_i) begin
    if (rx_stall_left != 0) begin
      rx_stall_left   <= rx_stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (rst_ni && rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
      rx_stall_left   <= $urandom_range(0, 13);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= rst_ni;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
  endtask

  // Ordered insert / remove-all on the shadow table; returns the expected word
  function automatic table_result_t apply_to_shadow(input logic cmd,
                                                    input logic signed [VALUE_W-1:0] v);
    table_result_t r;
    int pos;
    int k;
    int copies;
    r = '0;
    if (cmd == CMD_INSERT) begin
      if (shadow_count < CAPACITY) begin
        pos = 0;
        while (pos < shadow_count && shadow_vals[pos] <= v) pos++;
        for (k = shadow_count; k > pos; k--) shadow_vals[k] = shadow_vals[k-1];
        shadow_vals[pos] = v;
        shadow_count++;
        r.ok = 1'b1;
      end
    end else begin
      pos = 0;
      while (pos < shadow_count && shadow_vals[pos] != v) pos++;
      copies = 0;
      while (pos + copies < shadow_count && shadow_vals[pos+copies] == v) copies++;
      if (copies != 0) begin
        for (k = pos; k + copies < shadow_count; k++) shadow_vals[k] = shadow_vals[k+copies];
        shadow_count -= copies;
        r.ok = 1'b1;
      end
      r.removed_count = copies[CNT_OUT_W-1:0];
    end
    r.entry_count = shadow_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  // Send one word, with an optional leading gap; predict on acceptance
  task automatic send_word(input logic cmd, input logic signed [VALUE_W-1:0] v);
    table_result_t want_r;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    want_r = apply_to_shadow(cmd, v);
    pending_results.push_back(want_r);
    sent_count++;
    if (cmd == CMD_INSERT) begin
      if (want_r.ok) n_ins_ok++;
      else n_ins_full++;
    end else begin
      if (want_r.ok) n_rm_ok++;
      else n_rm_absent++;
      if (int'(want_r.removed_count) > max_copies) max_copies = int'(want_r.removed_count);
    end
  endtask

  // Mostly values that collide: stored ones, a small pool, extremes; some wide random
  function automatic logic signed [VALUE_W-1:0] choose_value(input int stored_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (shadow_count != 0 && pick < stored_pct)
      return shadow_vals[$urandom_range(0, shadow_count - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 45) return $signed($urandom_range(0, 8)) - 4;
    if (pick < 60) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_MIN + 1;
        default: return VAL_MAX - 1;
      endcase
    end
    return $signed($urandom);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, tdata", int'(m_axis_tdata_o), 0);
      end else begin
        head_r = pending_results.pop_front();
        if (m_axis_tdata_o[0] !== head_r.ok)
          report_mismatch("ok", int'(m_axis_tdata_o[0]), int'(head_r.ok));
        if (m_axis_tdata_o[5:1] !== head_r.entry_count)
          report_mismatch("entry_count", int'(m_axis_tdata_o[5:1]),
                          int'(head_r.entry_count));
        if (m_axis_tdata_o[10:6] !== head_r.removed_count)
          report_mismatch("removed_count", int'(m_axis_tdata_o[10:6]),
                          int'(head_r.removed_count));
      end
    end
  end

  // Empty remove, both extremes, duplicates, absent remove
  task automatic test_empty_and_extremes();
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    send_word(CMD_REMOVE, 0);
    send_word(CMD_INSERT, VAL_MAX);
    send_word(CMD_INSERT, VAL_MIN);
    send_word(CMD_INSERT, 0);
    send_word(CMD_INSERT, -1);
    send_word(CMD_INSERT, 0);
    send_word(CMD_INSERT, 1);
    send_word(CMD_REMOVE, 0);
    send_word(CMD_REMOVE, 5);
    send_word(CMD_REMOVE, VAL_MIN);
  endtask

  // Fill to capacity with alternating bit patterns, then one insert too many
  task automatic test_fill_to_capacity();
    int k;
    for (k = 0; k < 13; k++)
      send_word(CMD_INSERT, (k % 2) ? 32'shaaaa_aaaa : 32'sh5555_5555);
    send_word(CMD_INSERT, VAL_MIN);
  endtask

  // Random ops that swing between filling and draining, plus runs of one value
  task automatic test_random_traffic(input int n_items, input bit with_idling);
    int start;
    int k;
    logic signed [VALUE_W-1:0] v;
    start = sent_count;
    while (sent_count - start < n_items) begin
      if ((sent_count - start) % 100 == 0) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        if (with_idling) begin
          case ($urandom_range(0, 3))
            0: ;
            1: begin tx_gap_pct = 10; rx_stall_pct = 10; end
            2: begin tx_gap_pct = 40; rx_stall_pct = 40; end
            default: begin tx_gap_pct = 30; rx_stall_pct = 5; end
          endcase
        end
      end
      if ($urandom_range(0, 99) < 2) begin
        // drain, fill with copies of one value, overflow once, remove them all
        v = choose_value(0);
        while (shadow_count != 0) send_word(CMD_REMOVE, shadow_vals[0]);
        for (k = 0; k < CAPACITY; k++) send_word(CMD_INSERT, v);
        send_word(CMD_INSERT, v);
        send_word(CMD_REMOVE, v);
      end else begin
        if (shadow_count == CAPACITY && $urandom_range(0, 1)) insert_pct = 30;
        if (shadow_count == 0) insert_pct = 75;
        if ($urandom_range(0, 99) < insert_pct) send_word(CMD_INSERT, choose_value(25));
        else send_word(CMD_REMOVE, choose_value(65));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_extremes();
    test_fill_to_capacity();
    test_random_traffic(1400, 1'b1);
    test_random_traffic(200, 1'b0);

    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d words: %0d inserts (%0d refused full), %0d removes (%0d absent)",
             sent_count, n_ins_ok + n_ins_full, n_ins_full, n_rm_ok + n_rm_absent,
             n_rm_absent);
    $display("largest single remove %0d copies, %0d mismatches", max_copies, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
